// ===== design/ble_pkg.sv =====
// Shared types and constants for the bounded integer list engine.
`timescale 1ns / 1ps
`default_nettype none

package ble_pkg;

	localparam int DEPTH_DEF      = 256;
	localparam int VALUE_BITS_DEF = 32;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_READ       = 3'd4,
		CMD_WRITE      = 3'd5,
		CMD_SEARCH     = 3'd6
	} cmd_e;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_e;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_EXEC
	} state_e;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic               found;
		logic [8:0]         entry_count;
		status_e            status;
	} res_t;

endpackage

`default_nettype wire

// ===== design/ble_if.sv =====
// Command and result channel interfaces of the list engine.
`timescale 1ns / 1ps
`default_nettype none

interface ble_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         command;
	logic [7:0]         position;
	logic signed [31:0] value;

	modport source (output valid, output command, output position, output value, input ready);
	modport sink   (input valid, input command, input position, input value, output ready);
endinterface

interface ble_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] read_value;
	logic               found;
	logic [8:0]         entry_count;
	logic [1:0]         status;

	modport source (output valid, output read_value, output found, output entry_count,
		output status, input ready);
	modport sink   (input valid, input read_value, input found, input entry_count,
		input status, output ready);
endinterface

`default_nettype wire

// ===== design/ble_ram.sv =====
// Single-port-write, single-port-read entry store with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ble_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== design/ble_ctrl.sv =====
// Command sequencer: ring pointers, store accesses, search scan and result forming.
`timescale 1ns / 1ps
`default_nettype none

module ble_ctrl import ble_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int AW        = $clog2(DEPTH),
	localparam int CW        = $clog2(DEPTH + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	ble_cmd_if.sink                    cmd,
	output logic                       ram_we,
	output logic      [AW-1:0]         ram_waddr,
	output logic      [VALUE_BITS-1:0] ram_wdata,
	output logic                       ram_re,
	output logic      [AW-1:0]         ram_raddr,
	input  wire logic [VALUE_BITS-1:0] ram_rdata,
	output logic                       res_valid,
	output res_t                       res_data,
	input  wire logic                  res_ready
);

	state_e                state_q, state_d;
	logic [AW-1:0]         head_q, head_d;
	logic [CW-1:0]         count_q, count_d;
	status_e               status_q, st_d;
	logic                  use_rd_q, use_rd_d;
	logic                  found_q;
	logic [VALUE_BITS-1:0] key_q, key;
	logic [AW-1:0]         scan_ptr_q;
	logic [CW-1:0]         scan_left_q;
	logic                  cmp_valid_q;
	logic                  acc, hit, is_empty, is_full, pos_bad;
	logic [63:0]           val_w, rd_w;
	logic [31:0]           cnt_w;

	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head, input logic [AW:0] off);
		logic [AW:0] sum;
		sum = {1'b0, head} + off;
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
	endfunction

	assign val_w     = {32'd0, cmd.value};
	assign key       = val_w[VALUE_BITS-1:0];
	assign ram_wdata = key;
	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q == CW'(DEPTH));
	assign pos_bad   = 32'(cmd.position) >= 32'(count_q);
	assign hit       = cmp_valid_q && (ram_rdata == key_q);
	assign cmd.ready = (state_q == S_IDLE);
	assign acc       = cmd.valid && (state_q == S_IDLE);

	always_comb begin
		state_d   = state_q;
		st_d      = ST_OK;
		use_rd_d  = 1'b0;
		head_d    = head_q;
		count_d   = count_q;
		ram_we    = 1'b0;
		ram_waddr = head_q;
		ram_re    = 1'b0;
		ram_raddr = head_q;
		res_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					state_d = S_EXEC;
					unique case (cmd_e'(cmd.command))
						CMD_PUSH_FRONT: begin
							if (is_full) begin
								st_d = ST_FULL;
							end else begin
								head_d    = ptr_dec(head_q);
								ram_we    = 1'b1;
								ram_waddr = ptr_dec(head_q);
								count_d   = count_q + CW'(1);
							end
						end
						CMD_PUSH_BACK: begin
							if (is_full) begin
								st_d = ST_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = slot_of(head_q, (AW+1)'(count_q));
								count_d   = count_q + CW'(1);
							end
						end
						CMD_POP_FRONT: begin
							if (is_empty) begin
								st_d = ST_EMPTY;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = head_q;
								use_rd_d  = 1'b1;
								head_d    = ptr_inc(head_q);
								count_d   = count_q - CW'(1);
							end
						end
						CMD_POP_BACK: begin
							if (is_empty) begin
								st_d = ST_EMPTY;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = slot_of(head_q, (AW+1)'(count_q - CW'(1)));
								use_rd_d  = 1'b1;
								count_d   = count_q - CW'(1);
							end
						end
						CMD_READ: begin
							if (pos_bad) begin
								st_d = ST_BADPOS;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = slot_of(head_q, (AW+1)'(cmd.position));
								use_rd_d  = 1'b1;
							end
						end
						CMD_WRITE: begin
							if (pos_bad) begin
								st_d = ST_BADPOS;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = slot_of(head_q, (AW+1)'(cmd.position));
							end
						end
						CMD_SEARCH: begin
							if (!is_empty) begin
								state_d = S_SCAN;
							end
						end
						default: begin
							// unused code: no operation
						end
					endcase
				end
			end
			S_SCAN: begin
				ram_re    = (scan_left_q != '0) && !hit;
				ram_raddr = scan_ptr_q;
				if (hit || (scan_left_q == '0 && !cmp_valid_q)) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			cmp_valid_q <= 1'b0;
		end else if (acc) begin
			head_q      <= head_d;
			count_q     <= count_d;
			cmp_valid_q <= 1'b0;
		end else if (state_q == S_SCAN) begin
			cmp_valid_q <= ram_re;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_q    <= st_d;
			use_rd_q    <= use_rd_d;
			key_q       <= key;
			found_q     <= 1'b0;
			scan_ptr_q  <= head_q;
			scan_left_q <= count_q;
		end else if (state_q == S_SCAN) begin
			if (ram_re) begin
				scan_ptr_q  <= ptr_inc(scan_ptr_q);
				scan_left_q <= scan_left_q - CW'(1);
			end
			if (hit) begin
				found_q <= 1'b1;
			end
		end
	end

	// read data holds in the store's output register until the result is taken
	assign rd_w  = 64'(ram_rdata);
	assign cnt_w = 32'(count_q);

	always_comb begin
		res_data.read_value  = use_rd_q ? signed'(rd_w[31:0]) : 32'sd0;
		res_data.found       = found_q;
		res_data.entry_count = cnt_w[8:0];
		res_data.status      = status_q;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= DEPTH)
		else $error("entry count exceeds depth");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("store read and write in the same cycle");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> state_q != S_IDLE)
		else $error("accepted transaction did not start work");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(head_q) < DEPTH)
		else $error("head pointer out of range");

	a_scan_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && hit) |=> state_q == S_EXEC)
		else $error("search hit did not end the scan");

endmodule

`default_nettype wire

// ===== design/bounded_int_list_engine.sv =====
// Bounded integer list engine: a deque of signed values with indexed access and search.
//
// Commands arrive on the cmd channel (valid/ready); one result per command leaves on
// the res channel. A transaction is taken at a clock edge where valid and ready are high.
// Push, pop, read and write do their single store access and pointer update in the
// accept cycle, and the next cycle forms the result from the store's registered read
// data. Search walks the list from the front, one store read per cycle, and stops on the
// first match or after the last entry. The single-read store port sets the search time.
// The result lands in an output register, so a new command is taken while a finished
// result still waits; when the receiver stalls, the next result waits in the sequencer
// and no further command is taken until the output register frees.
// Reset (arst_n low) empties the list and clears head pointer and count at once; the
// store contents need no clearing since only written entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module bounded_int_list_engine import ble_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	ble_cmd_if.sink  cmd,
	ble_res_if.source res
);

	localparam int AW = $clog2(DEPTH);

	logic                  ram_we, ram_re;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [VALUE_BITS-1:0] ram_wdata, ram_rdata;
	logic                  res_valid, res_ready;
	res_t                  res_data;
	logic                  out_valid_q;
	res_t                  out_q;

	ble_ctrl #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.res_valid (res_valid),
		.res_data  (res_data),
		.res_ready (res_ready)
	);

	ble_ram #(
		.DEPTH (DEPTH),
		.WIDTH (VALUE_BITS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register: load when empty or being drained this cycle
	assign res_ready = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res_data;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.read_value  = out_q.read_value;
	assign res.found       = out_q.found;
	assign res.entry_count = out_q.entry_count;
	assign res.status      = out_q.status;

endmodule

`default_nettype wire

// ===== tb/bounded_int_list_engine_tb.sv =====
// Self-checking testbench for the list engine: directed and random commands, random stalls.
`timescale 1ns / 1ps

module bounded_int_list_engine_tb;
	import ble_pkg::*;

	localparam int         DEPTH        = DEPTH_DEF;
	localparam logic [2:0] CMD_UNUSED   = 3'd7;
	localparam int         IDLE_MAX     = 18;
	localparam int         RANDOM_ITEMS = 1150;
	localparam int         HOLD_AFTER   = 300;
	localparam int         HOLD_CYCLES  = 1000;
	localparam int         DRAIN_CYCLES = 20;
	localparam int         CYCLE_LIMIT  = 2000000;

	typedef struct packed {
		logic [2:0]         command;
		logic [7:0]         position;
		logic signed [31:0] value;
	} list_cmd_t;

	logic clk;
	logic arst_n;

	ble_cmd_if cmd_ch ();
	ble_res_if res_ch ();

	bounded_int_list_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	// Shadow copy of the list, updated as each command transaction is taken
	logic signed [31:0] shadow_mem [DEPTH];
	int shadow_head;
	int shadow_count;

	list_cmd_t pending_cmds [$];
	res_t      expected_res [$];

	int gen_count;
	int total_items;
	int accepted_count;
	int checked_count;
	int error_count;
	int cycle_count;
	int send_wait, send_run;
	int recv_wait, recv_run;
	int full_seen, empty_seen, badpos_seen, hits_seen;
	logic hold_off;

	function automatic int slot_at(input int pos);
		return (shadow_head + pos) % DEPTH;
	endfunction

	function automatic res_t apply_to_shadow(input list_cmd_t c);
		res_t r;
		r.read_value = '0;
		r.found      = 1'b0;
		r.status     = ST_OK;
		case (c.command)
		CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
			if (shadow_count >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				if (c.command == CMD_PUSH_FRONT) begin
					shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
					shadow_mem[shadow_head] = c.value;
				end else begin
					shadow_mem[slot_at(shadow_count)] = c.value;
				end
				shadow_count++;
			end
		end
		CMD_POP_FRONT, CMD_POP_BACK: begin
			if (shadow_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				if (c.command == CMD_POP_FRONT) begin
					r.read_value = shadow_mem[shadow_head];
					shadow_head = (shadow_head + 1) % DEPTH;
				end else begin
					r.read_value = shadow_mem[slot_at(shadow_count - 1)];
				end
				shadow_count--;
			end
		end
		CMD_READ, CMD_WRITE: begin
			if (int'(c.position) >= shadow_count) begin
				r.status = ST_BADPOS;
			end else if (c.command == CMD_READ) begin
				r.read_value = shadow_mem[slot_at(c.position)];
			end else begin
				shadow_mem[slot_at(c.position)] = c.value;
			end
		end
		CMD_SEARCH: begin
			for (int i = 0; i < shadow_count; i++) begin
				if (shadow_mem[slot_at(i)] == c.value) begin
					r.found = 1'b1;
					break;
				end
			end
		end
		default: ;
		endcase
		r.entry_count = 9'(shadow_count);
		return r;
	endfunction

	// Idle cycles before the next transaction, with occasional runs of back-to-back traffic
	function automatic int draw_idle(inout int run_left);
		if (run_left > 0) begin
			run_left--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0) begin
			run_left = $urandom_range(20, 60);
			return 0;
		end
		if ($urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, IDLE_MAX);
	endfunction

	function automatic list_cmd_t make_cmd(input logic [2:0] op, input logic [7:0] pos,
		input logic [31:0] val);
		list_cmd_t c;
		c.command  = op;
		c.position = pos;
		c.value    = val;
		return c;
	endfunction

	// A small pool of repeated values keeps searches hitting often
	function automatic logic [31:0] pick_value();
		logic [31:0] pool [8];
		pool = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
			32'h0000_0001, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_002a};
		if ($urandom_range(0, 9) < 4)
			return pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	function automatic logic [7:0] pick_position();
		if (gen_count > 0 && $urandom_range(0, 9) < 8)
			return 8'($urandom_range(0, (gen_count > 256 ? 256 : gen_count) - 1));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic add_cmd(input list_cmd_t c);
		pending_cmds.push_back(c);
		if (c.command == CMD_PUSH_FRONT || c.command == CMD_PUSH_BACK) begin
			if (gen_count < DEPTH)
				gen_count++;
		end else if (c.command == CMD_POP_FRONT || c.command == CMD_POP_BACK) begin
			if (gen_count > 0)
				gen_count--;
		end
	endtask

	task automatic add_random_cmd(input int push_w, input int pop_w);
		list_cmd_t c;
		int roll;
		roll       = $urandom_range(0, 99);
		c.position = pick_position();
		c.value    = pick_value();
		if (roll < 4) begin
			// noise: any code, unused one included, any position
			c.command  = 3'($urandom_range(0, 7));
			c.position = 8'($urandom_range(0, 255));
		end else if (roll < 4 + push_w) begin
			c.command = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
		end else if (roll < 4 + push_w + pop_w) begin
			c.command = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
		end else begin
			case ($urandom_range(0, 2))
			0: c.command = CMD_READ;
			1: c.command = CMD_WRITE;
			default: c.command = CMD_SEARCH;
			endcase
		end
		add_cmd(c);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		cycle_count++;

	// Command driver
	always @(posedge clk or negedge arst_n) begin : cmd_driver
		list_cmd_t taken;
		list_cmd_t next_cmd;
		if (!arst_n) begin
			cmd_ch.valid    <= 1'b0;
			cmd_ch.command  <= '0;
			cmd_ch.position <= '0;
			cmd_ch.value    <= '0;
			send_wait = 0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				taken.command  = cmd_ch.command;
				taken.position = cmd_ch.position;
				taken.value    = cmd_ch.value;
				expected_res.push_back(apply_to_shadow(taken));
				accepted_count++;
				send_wait = draw_idle(send_run);
			end
			// hold the offered item until it is taken
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (send_wait > 0 || pending_cmds.size() == 0) begin
					if (send_wait > 0)
						send_wait--;
					cmd_ch.valid <= 1'b0;
				end else begin
					next_cmd = pending_cmds.pop_front();
					cmd_ch.valid    <= 1'b1;
					cmd_ch.command  <= next_cmd.command;
					cmd_ch.position <= next_cmd.position;
					cmd_ch.value    <= next_cmd.value;
				end
			end
		end
	end

	// Result monitor and checker
	always @(posedge clk or negedge arst_n) begin : result_mon
		res_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			recv_wait = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				checked_count++;
				if (expected_res.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("unexpected result: value %0d found %0b count %0d status %0d",
							res_ch.read_value, res_ch.found, res_ch.entry_count,
							res_ch.status);
				end else begin
					want = expected_res.pop_front();
					if (res_ch.read_value !== want.read_value || res_ch.found !== want.found ||
						res_ch.entry_count !== want.entry_count ||
						res_ch.status !== want.status) begin
						error_count++;
						if (error_count <= 10) begin
							$display("mismatch on result %0d: expected value %0d found %0b count %0d status %0d",
								checked_count, want.read_value, want.found,
								want.entry_count, want.status);
							$display("  got value %0d found %0b count %0d status %0d",
								res_ch.read_value, res_ch.found, res_ch.entry_count,
								res_ch.status);
						end
					end
					case (want.status)
					ST_FULL:   full_seen++;
					ST_EMPTY:  empty_seen++;
					ST_BADPOS: badpos_seen++;
					default:   ;
					endcase
					if (want.found)
						hits_seen++;
				end
				recv_wait = draw_idle(recv_run);
			end else if (recv_wait > 0) begin
				recv_wait--;
			end
			res_ch.ready <= (recv_wait == 0) && !hold_off;
		end
	end

	// Long receiver stall so the engine backs up and refuses commands
	initial begin
		hold_off = 1'b0;
		wait (accepted_count >= HOLD_AFTER);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("[bounded_int_list_engine] ERROR");
		$finish;
	end

	initial begin
		int target;
		int len;
		arst_n          = 1'b0;
		cmd_ch.valid    = 1'b0;
		cmd_ch.command  = '0;
		cmd_ch.position = '0;
		cmd_ch.value    = '0;
		res_ch.ready    = 1'b0;
		shadow_head     = 0;
		shadow_count    = 0;
		gen_count       = 0;
		accepted_count  = 0;
		checked_count   = 0;
		error_count     = 0;
		cycle_count     = 0;
		send_run        = 0;
		recv_run        = 0;
		full_seen       = 0;
		empty_seen      = 0;
		badpos_seen     = 0;
		hits_seen       = 0;

		// Empty list: pops, accesses and search all fail or miss
		add_cmd(make_cmd(CMD_POP_FRONT, 8'd0, 32'h0));
		add_cmd(make_cmd(CMD_POP_BACK, 8'd0, 32'h0));
		add_cmd(make_cmd(CMD_READ, 8'd0, 32'h0));
		add_cmd(make_cmd(CMD_WRITE, 8'd255, 32'hffff_ffff));
		add_cmd(make_cmd(CMD_SEARCH, 8'd0, 32'h0));
		add_cmd(make_cmd(CMD_UNUSED, 8'd0, 32'h0));
		// Extreme values at both ends
		add_cmd(make_cmd(CMD_PUSH_BACK, 8'd0, 32'h7fff_ffff));
		add_cmd(make_cmd(CMD_PUSH_FRONT, 8'd0, 32'h8000_0000));
		add_cmd(make_cmd(CMD_PUSH_BACK, 8'd0, 32'h0000_0000));
		add_cmd(make_cmd(CMD_PUSH_FRONT, 8'd0, 32'hffff_ffff));
		add_cmd(make_cmd(CMD_READ, 8'd0, 32'h0));
		add_cmd(make_cmd(CMD_READ, 8'd3, 32'h0));
		add_cmd(make_cmd(CMD_READ, 8'd4, 32'h0));
		add_cmd(make_cmd(CMD_READ, 8'd255, 32'h0));
		add_cmd(make_cmd(CMD_WRITE, 8'd2, 32'h5a5a_5a5a));
		add_cmd(make_cmd(CMD_READ, 8'd2, 32'h0));
		add_cmd(make_cmd(CMD_WRITE, 8'd4, 32'h1234_5678));
		add_cmd(make_cmd(CMD_SEARCH, 8'd0, 32'hffff_ffff));
		add_cmd(make_cmd(CMD_SEARCH, 8'd0, 32'h7fff_ffff));
		add_cmd(make_cmd(CMD_SEARCH, 8'd0, 32'h1234_5678));
		add_cmd(make_cmd(CMD_POP_FRONT, 8'd0, 32'h0));
		add_cmd(make_cmd(CMD_POP_BACK, 8'd0, 32'h0));
		add_cmd(make_cmd(CMD_UNUSED, 8'd255, 32'hffff_ffff));

		target = pending_cmds.size() + RANDOM_ITEMS;

		// Climb to full with mixed traffic, then knock on the full list
		while (gen_count < DEPTH)
			add_random_cmd(75, 5);
		add_cmd(make_cmd(CMD_PUSH_BACK, 8'd0, pick_value()));
		add_cmd(make_cmd(CMD_PUSH_FRONT, 8'd0, pick_value()));
		add_cmd(make_cmd(CMD_READ, 8'd255, 32'h0));
		add_cmd(make_cmd(CMD_WRITE, 8'd255, pick_value()));
		add_cmd(make_cmd(CMD_SEARCH, 8'd0, 32'h1357_9bdf));
		repeat (60)
			add_random_cmd(35, 35);
		// Drain to empty and pop past the bottom
		while (gen_count > 0)
			add_random_cmd(5, 75);
		add_cmd(make_cmd(CMD_POP_BACK, 8'd0, 32'h0));
		add_cmd(make_cmd(CMD_POP_FRONT, 8'd0, 32'h0));
		add_cmd(make_cmd(CMD_READ, 8'd0, 32'h0));

		while (pending_cmds.size() < target) begin
			len = $urandom_range(30, 90);
			case ($urandom_range(0, 2))
			0: repeat (len) add_random_cmd(60, 20);
			1: repeat (len) add_random_cmd(20, 60);
			default: repeat (len) add_random_cmd(35, 35);
			endcase
		end
		total_items = pending_cmds.size();

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (accepted_count < total_items || expected_res.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d commands and %0d results in %0d cycles", accepted_count,
			checked_count, cycle_count);
		$display("statuses seen: %0d full, %0d empty, %0d bad position; %0d search hits",
			full_seen, empty_seen, badpos_seen, hits_seen);
		if (error_count == 0) begin
			$display("[bounded_int_list_engine] OK");
		end else begin
			$display("%0d mismatches", error_count);
			$display("[bounded_int_list_engine] ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/ble_pkg.sv
design/ble_if.sv
design/ble_ram.sv
design/ble_ctrl.sv
design/bounded_int_list_engine.sv
tb/bounded_int_list_engine_tb.sv
